FILE: hw/rtl/kpa_pkg.sv
// Shared types, register indexes and constants of the key auto-repeat unit.
package kpa_pkg;

    localparam int NUM_KEYS_DEF = 8;
    // The enable mask is eight bits wide, so no key above seven is ever scanned.
    localparam int MAX_SCAN     = 8;
    localparam int CFG_DW       = 16;

    localparam logic [15:0] LONG_PRESS_RST    = 16'd500;
    localparam logic [15:0] REPEAT_PERIOD_RST = 16'd100;

    localparam logic [1:0] OP_DOWN = 2'd0;
    localparam logic [1:0] OP_UP   = 2'd1;

    localparam logic KIND_PRESS  = 1'b0;
    localparam logic KIND_REPEAT = 1'b1;

    typedef enum logic [1:0] {
        CFG_LONG_PRESS    = 2'd0,
        CFG_REPEAT_PERIOD = 2'd1,
        CFG_REPEAT_MASK   = 2'd2,
        CFG_REPORT_EN     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  key_index;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [2:0] report_key;
        logic       report_kind;
        logic       last_report;
    } t_out_word;

    typedef struct packed {
        logic                go;
        logic                press;
        logic [2:0]          press_key;
        logic [MAX_SCAN-1:0] rep_mask;
    } t_emit_req;

endpackage

FILE: hw/rtl/key_press_autorepeat_unit.sv
// Key auto-repeat unit: held-key tracking, press time store, repeat scan and report output.
// One input word is taken at a time. The accepting cycle updates the held bits, stores the
// press time and tests the repeat period; when a scan is due, the press time memory is read
// once per key, for min(NUM_KEYS, 8) keys; the last hit is collected in the drain state, the
// issue state hands the hits to the emitter, and the reports then leave one at a time through
// the output register. The input stalls throughout, while the final report of a word may
// still wait at the output when the next word is taken.
module key_press_autorepeat_unit import kpa_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word
);

    localparam int NS = (NUM_KEYS < MAX_SCAN) ? NUM_KEYS : MAX_SCAN;
    localparam int IW = (NS > 1) ? $clog2(NS) : 1;
    localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_ISSUE} t_state;

    t_state              r_state;
    logic [15:0]         r_long;
    logic [15:0]         r_period;
    logic [7:0]          r_mask;
    logic                r_rep_en;
    logic [NUM_KEYS-1:0] r_held;
    logic [31:0]         r_last_scan;
    logic [31:0]         r_now;
    logic                r_press;
    logic [2:0]          r_pkey;
    logic [IW-1:0]       r_idx;
    logic                r_cmp_vld;
    logic [IW-1:0]       r_cmp_idx;
    logic [NS-1:0]       r_rep;

    logic          in_acc;
    logic          key_ok;
    logic [AW-1:0] key_addr;
    logic          is_edge;
    logic          scan_due;
    logic          hit;
    logic          emit_busy;
    logic [31:0]   rdata;
    t_emit_req     req;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign key_ok   = {3'b000, i_in_word.key_index} < 6'(NUM_KEYS);
    assign key_addr = AW'(i_in_word.key_index);
    assign is_edge  = key_ok && (i_in_word.operation == OP_DOWN) && !r_held[key_addr];
    assign scan_due = (i_in_word.now_ms - r_last_scan) >= {16'd0, r_period};

    assign o_in_stall = (r_state != ST_IDLE) || emit_busy;

    // Read data belongs to the key addressed in the previous cycle.
    assign hit = r_rep_en && r_mask[3'(r_cmp_idx)] && r_held[AW'(r_cmp_idx)]
                 && ((r_now - rdata) >= {16'd0, r_long});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long   <= LONG_PRESS_RST;
            r_period <= REPEAT_PERIOD_RST;
            r_mask   <= '0;
            r_rep_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LONG_PRESS:    r_long   <= i_cfg_data;
                CFG_REPEAT_PERIOD: r_period <= i_cfg_data;
                CFG_REPEAT_MASK:   r_mask   <= i_cfg_data[7:0];
                CFG_REPORT_EN:     r_rep_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_held      <= '0;
            r_last_scan <= '0;
            r_press     <= 1'b0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_rep       <= '0;
        end else begin
            r_cmp_vld <= 1'b0;
            if (r_cmp_vld) begin
                r_rep[r_cmp_idx] <= hit;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_now   <= i_in_word.now_ms;
                        r_press <= is_edge && r_rep_en;
                        r_pkey  <= i_in_word.key_index;
                        if (key_ok) begin
                            if (i_in_word.operation == OP_DOWN) begin
                                r_held[key_addr] <= 1'b1;
                            end else if (i_in_word.operation == OP_UP) begin
                                r_held[key_addr] <= 1'b0;
                            end
                        end
                        if (scan_due) begin
                            r_last_scan <= i_in_word.now_ms;
                            r_idx       <= '0;
                            r_rep       <= '0;
                            r_state     <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_cmp_vld <= 1'b1;
                    r_cmp_idx <= r_idx;
                    if (r_idx == IW'(NS - 1)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        if (r_state == ST_ISSUE) begin
            req.go        = 1'b1;
            req.press     = r_press;
            req.press_key = r_pkey;
            req.rep_mask  = MAX_SCAN'(r_rep);
        end else begin
            req.go        = in_acc && !scan_due;
            req.press     = is_edge && r_rep_en;
            req.press_key = i_in_word.key_index;
            req.rep_mask  = '0;
        end
    end

    kpa_time_mem #(
        .DEPTH (NUM_KEYS),
        .AW    (AW)
    ) u_time_mem (
        .i_clk   (i_clk),
        .i_we    (in_acc && is_edge),
        .i_waddr (key_addr),
        .i_wdata (i_in_word.now_ms),
        .i_raddr (AW'(r_idx)),
        .o_rdata (rdata)
    );

    kpa_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_busy      (emit_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: hw/rtl/kpa_time_mem.sv
// Press time store: one write port, one read port with registered read data.
module kpa_time_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/kpa_emitter.sv
// Report sequencer: press report first, then repeats in rising key order, through an output register.
module kpa_emitter import kpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_emit_req i_req,
    output logic      o_busy,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic                r_press;
    logic [2:0]          r_key;
    logic [MAX_SCAN-1:0] r_rep;
    logic                r_ovalid;
    t_out_word           r_oword;

    logic                free;
    logic [2:0]          low_idx;
    logic [MAX_SCAN-1:0] low_bit;
    logic [MAX_SCAN-1:0] rest;

    always_comb begin
        low_idx = '0;
        for (int k = MAX_SCAN - 1; k >= 0; k--) begin
            if (r_rep[k]) begin
                low_idx = 3'(k);
            end
        end
        low_bit = r_rep & (~r_rep + MAX_SCAN'(1));
        rest    = r_rep & ~low_bit;
        free    = !r_ovalid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press  <= 1'b0;
            r_rep    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_req.go) begin
                r_press <= i_req.press;
                r_key   <= i_req.press_key;
                r_rep   <= i_req.rep_mask;
            end else if (free) begin
                // The last flag is known here because all repeat hits are already collected.
                if (r_press) begin
                    r_ovalid <= 1'b1;
                    r_oword  <= '{report_key: r_key, report_kind: KIND_PRESS,
                                  last_report: (r_rep == '0)};
                    r_press  <= 1'b0;
                end else if (r_rep != '0) begin
                    r_ovalid <= 1'b1;
                    r_oword  <= '{report_key: low_idx, report_kind: KIND_REPEAT,
                                  last_report: (rest == '0)};
                    r_rep    <= rest;
                end
            end
        end
    end

    assign o_busy      = r_press || (r_rep != '0);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

endmodule
